[sv/aapf_pkg.sv]
// aapf_pkg: widths, stage counts and stage record types for the alignment pair force pipeline
`default_nettype none
package aapf_pkg;

   // field widths
   localparam int DISP_W   = 24;
   localparam int DIR_W    = 16;
   localparam int FORCE_W  = 32;
   localparam int ALPHA_W  = 24;
   localparam int CUTOFF_W = 23;
   localparam int CSR_W    = 24;

   // register indexes
   localparam logic CSR_ALPHA  = 1'b0;
   localparam logic CSR_CUTOFF = 1'b1;

   // internal widths
   localparam int DN_W    = DIR_W + 1;            // director difference
   localparam int DNM_W   = DIR_W;                // its magnitude
   localparam int D2_W    = 2 * DISP_W - 1;       // one squared displacement
   localparam int R2_W    = D2_W + 2;             // squared distance
   localparam int CUT2_W  = 2 * CUTOFF_W;         // squared cutoff
   localparam int DOT_W   = 2 * DIR_W + 2;        // signed dot product
   localparam int DOTM_W  = 2 * DIR_W;            // its magnitude
   localparam int L2_W    = 2 * DNM_W + 2;        // squared difference length
   localparam int NUM_W   = ALPHA_W + DOTM_W;     // dividend
   localparam int SQX_W   = L2_W + 28;            // radicand
   localparam int LEN_W   = SQX_W / 2;            // root
   localparam int SQ_STEPS = LEN_W;
   localparam int SQREM_W = LEN_W + 3;
   localparam int DEN_W   = LEN_W + 1;
   localparam int DV_STEPS = NUM_W;
   localparam int LO_W    = 32;
   localparam int HI_W    = NUM_W - LO_W;
   localparam int M_W     = NUM_W + DNM_W - 14;   // force magnitude before clipping

   // values that travel with an item through the long stages
   typedef struct packed {
      logic [2:0][DN_W-1:0] dn;
      logic                 applied;
   } carry_type;

   // square root stage
   typedef struct packed {
      logic [SQREM_W-1:0] rem;
      logic [LEN_W-1:0]   res;
      logic [L2_W-1:0]    l2;
      logic [NUM_W-1:0]   num;
   } sq_type;

   // division stage
   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] q;
      logic [DEN_W-1:0] den;
      logic             zero_len;
   } dv_type;

endpackage
`default_nettype wire

[sv/active_alignment_pair_force_top.sv]
// active_alignment_pair_force_top: pipelined alignment force for one neighbour pair
`default_nettype none
// One pair enters per cycle unless the pipeline halts. Its force passes through three stages
// of products and sums, 31 stages of a bit-per-stage square root for |ni - nj|, a load stage
// and 56 stages of a bit-per-stage restoring divider for the force factor, two multiply stages
// and the output register. The whole pipeline moves as one and halts only while a finished
// result waits at the output and the receiver holds rsp_ready low; req_ready is then low too.
// Registers alpha and cutoff are to be written while no item is in flight.
module active_alignment_pair_force_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [23:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic signed [23:0] req_disp_x,
   input  wire logic signed [23:0] req_disp_y,
   input  wire logic signed [23:0] req_disp_z,
   input  wire logic signed [15:0] req_dir_i_x,
   input  wire logic signed [15:0] req_dir_i_y,
   input  wire logic signed [15:0] req_dir_i_z,
   input  wire logic signed [15:0] req_dir_j_x,
   input  wire logic signed [15:0] req_dir_j_y,
   input  wire logic signed [15:0] req_dir_j_z,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic signed [31:0] rsp_force_z,
   output logic             rsp_applied,
   output logic             rsp_saturated
);

   localparam int SQN = aapf_pkg::SQ_STEPS;
   localparam int DVN = aapf_pkg::DV_STEPS;

   // configuration registers
   logic [aapf_pkg::ALPHA_W-1:0]  alpha_ff;
   logic [aapf_pkg::CUTOFF_W-1:0] cutoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= aapf_pkg::ALPHA_W'(65536);
         cutoff_ff <= aapf_pkg::CUTOFF_W'(65536);
      end else if (csr_write) begin
         unique case (csr_index)
            aapf_pkg::CSR_ALPHA:  alpha_ff  <= csr_data[aapf_pkg::ALPHA_W-1:0];
            aapf_pkg::CSR_CUTOFF: cutoff_ff <= csr_data[aapf_pkg::CUTOFF_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline advances together
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // stage 1: products
   logic signed [aapf_pkg::DISP_W-1:0] disp [3];
   logic signed [aapf_pkg::DIR_W-1:0]  di [3];
   logic signed [aapf_pkg::DIR_W-1:0]  dj [3];
   assign disp = '{req_disp_x, req_disp_y, req_disp_z};
   assign di   = '{req_dir_i_x, req_dir_i_y, req_dir_i_z};
   assign dj   = '{req_dir_j_x, req_dir_j_y, req_dir_j_z};

   logic        s1_valid_ff;
   logic [aapf_pkg::D2_W-1:0]        d2_ff [3];
   logic signed [2*aapf_pkg::DIR_W-1:0] pd_ff [3];
   logic [2*aapf_pkg::DNM_W-1:0]     dn2_ff [3];
   logic [2:0][aapf_pkg::DN_W-1:0]   s1_dn_ff;
   logic [aapf_pkg::CUT2_W-1:0]      cut2_ff;

   logic signed [2*aapf_pkg::DISP_W-1:0] d2_full [3];
   logic signed [2*aapf_pkg::DN_W-1:0]   dn2_full [3];
   logic signed [aapf_pkg::DN_W-1:0]     dn_in [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dn_in[c]    = aapf_pkg::DN_W'(di[c]) - aapf_pkg::DN_W'(dj[c]);
         d2_full[c]  = disp[c] * disp[c];
         dn2_full[c] = dn_in[c] * dn_in[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            d2_ff[c]    <= d2_full[c][aapf_pkg::D2_W-1:0];
            pd_ff[c]    <= di[c] * dj[c];
            dn2_ff[c]   <= dn2_full[c][2*aapf_pkg::DNM_W-1:0];
            s1_dn_ff[c] <= dn_in[c];
         end
         cut2_ff <= cutoff_ff * cutoff_ff;
      end
   end

   // stage 2: sums and range test
   logic                              s2_valid_ff;
   logic signed [aapf_pkg::DOT_W-1:0] dot_ff;
   logic [aapf_pkg::L2_W-1:0]         l2_ff;
   aapf_pkg::carry_type               s2_carry_ff;
   logic [aapf_pkg::R2_W-1:0]         r2_in;
   logic signed [aapf_pkg::DOT_W-1:0] dot_in;

   always_comb begin
      r2_in  = aapf_pkg::R2_W'(d2_ff[0]) + aapf_pkg::R2_W'(d2_ff[1])
             + aapf_pkg::R2_W'(d2_ff[2]);
      dot_in = aapf_pkg::DOT_W'(pd_ff[0]) + aapf_pkg::DOT_W'(pd_ff[1])
             + aapf_pkg::DOT_W'(pd_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (adv) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dot_ff <= dot_in;
         l2_ff  <= aapf_pkg::L2_W'(dn2_ff[0]) + aapf_pkg::L2_W'(dn2_ff[1])
                 + aapf_pkg::L2_W'(dn2_ff[2]);
         s2_carry_ff.dn      <= s1_dn_ff;
         s2_carry_ff.applied <= (r2_in <= aapf_pkg::R2_W'(cut2_ff)) && (dot_in < 0);
      end
   end

   // stage 3: dividend alpha * |dot| for negative dot, start of the root
   logic [aapf_pkg::DOT_W-1:0] dot_neg;
   assign dot_neg = aapf_pkg::DOT_W'(-dot_ff);

   logic                sq_valid_ff [SQN+1];
   aapf_pkg::sq_type    sq_ff [SQN+1];
   aapf_pkg::carry_type sq_carry_ff [SQN+1];
   aapf_pkg::sq_type    sq_in [SQN];

   // one root bit per stage
   logic [aapf_pkg::SQX_W-1:0]   sq_x [SQN];
   logic [aapf_pkg::SQREM_W-1:0] sq_sh [SQN];
   logic [aapf_pkg::SQREM_W-1:0] sq_t [SQN];

   always_comb begin
      for (int k = 0; k < SQN; k++) begin
         sq_x[k]  = {sq_ff[k].l2, 28'd0};
         sq_sh[k] = {sq_ff[k].rem[aapf_pkg::SQREM_W-3:0],
                     sq_x[k][aapf_pkg::SQX_W-1-2*k -: 2]};
         sq_t[k]  = {1'b0, sq_ff[k].res, 2'b01};
         sq_in[k] = sq_ff[k];
         if (sq_sh[k] >= sq_t[k]) begin
            sq_in[k].rem = sq_sh[k] - sq_t[k];
            sq_in[k].res = {sq_ff[k].res[aapf_pkg::LEN_W-2:0], 1'b1};
         end else begin
            sq_in[k].rem = sq_sh[k];
            sq_in[k].res = {sq_ff[k].res[aapf_pkg::LEN_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SQN; k++) sq_valid_ff[k] <= 1'b0;
      end else if (adv) begin
         sq_valid_ff[0] <= s2_valid_ff;
         for (int k = 0; k < SQN; k++) sq_valid_ff[k+1] <= sq_valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff[0].rem   <= '0;
         sq_ff[0].res   <= '0;
         sq_ff[0].l2    <= l2_ff;
         sq_ff[0].num   <= alpha_ff * dot_neg[aapf_pkg::DOTM_W-1:0];
         sq_carry_ff[0] <= s2_carry_ff;
         for (int k = 0; k < SQN; k++) begin
            sq_ff[k+1]       <= sq_in[k];
            sq_carry_ff[k+1] <= sq_carry_ff[k];
         end
      end
   end

   // divider: one quotient bit per stage
   logic                dv_valid_ff [DVN+1];
   aapf_pkg::dv_type    dv_ff [DVN+1];
   aapf_pkg::carry_type dv_carry_ff [DVN+1];
   aapf_pkg::dv_type    dv_in [DVN];
   logic [aapf_pkg::DEN_W:0] dv_sh [DVN];

   always_comb begin
      for (int k = 0; k < DVN; k++) begin
         dv_sh[k] = {dv_ff[k].rem, dv_ff[k].q[aapf_pkg::NUM_W-1]};
         dv_in[k] = dv_ff[k];
         if (dv_sh[k] >= {1'b0, dv_ff[k].den}) begin
            dv_in[k].rem = aapf_pkg::DEN_W'(dv_sh[k] - {1'b0, dv_ff[k].den});
            dv_in[k].q   = {dv_ff[k].q[aapf_pkg::NUM_W-2:0], 1'b1};
         end else begin
            dv_in[k].rem = dv_sh[k][aapf_pkg::DEN_W-1:0];
            dv_in[k].q   = {dv_ff[k].q[aapf_pkg::NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DVN; k++) dv_valid_ff[k] <= 1'b0;
      end else if (adv) begin
         dv_valid_ff[0] <= sq_valid_ff[SQN];
         for (int k = 0; k < DVN; k++) dv_valid_ff[k+1] <= dv_valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0].rem      <= '0;
         dv_ff[0].q        <= sq_ff[SQN].num;
         dv_ff[0].den      <= {sq_ff[SQN].res, 1'b0};
         dv_ff[0].zero_len <= (sq_ff[SQN].res == '0);
         dv_carry_ff[0]    <= sq_carry_ff[SQN];
         for (int k = 0; k < DVN; k++) begin
            dv_ff[k+1]       <= dv_in[k];
            dv_carry_ff[k+1] <= dv_carry_ff[k];
         end
      end
   end

   // force multiply, factor split into a low 32-bit part and a high part
   logic [aapf_pkg::DNM_W-1:0] dn_mag [3];
   logic signed [aapf_pkg::DN_W-1:0] dn_last [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dn_last[c] = dv_carry_ff[DVN].dn[c];
         dn_mag[c]  = dn_last[c][aapf_pkg::DN_W-1]
                    ? aapf_pkg::DNM_W'(-dn_last[c])
                    : dn_last[c][aapf_pkg::DNM_W-1:0];
      end
   end

   logic                                    p_valid_ff;
   logic [aapf_pkg::LO_W+aapf_pkg::DNM_W-1:0] plo_ff [3];
   logic [aapf_pkg::HI_W+aapf_pkg::DNM_W-1:0] phi_ff [3];
   logic [2:0]                              p_pos_ff;
   logic                                    p_applied_ff;
   logic                                    p_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) p_valid_ff <= 1'b0;
      else if (adv) p_valid_ff <= dv_valid_ff[DVN];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            plo_ff[c]   <= dv_ff[DVN].q[aapf_pkg::LO_W-1:0] * dn_mag[c];
            phi_ff[c]   <= dv_ff[DVN].q[aapf_pkg::NUM_W-1:aapf_pkg::LO_W] * dn_mag[c];
            p_pos_ff[c] <= !dn_last[c][aapf_pkg::DN_W-1] && (dn_last[c] != '0);
         end
         p_applied_ff <= dv_carry_ff[DVN].applied;
         p_zero_ff    <= dv_ff[DVN].zero_len;
      end
   end

   // partial products combined
   localparam int FULL_W = aapf_pkg::NUM_W + aapf_pkg::DNM_W;
   logic                    m_valid_ff;
   logic [aapf_pkg::M_W-1:0] m_ff [3];
   logic [2:0]              m_pos_ff;
   logic                    m_applied_ff;
   logic                    m_zero_ff;
   logic [FULL_W-1:0]       m_full [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         m_full[c] = {phi_ff[c], {aapf_pkg::LO_W{1'b0}}} + FULL_W'(plo_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) m_valid_ff <= 1'b0;
      else if (adv) m_valid_ff <= p_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) m_ff[c] <= m_full[c][FULL_W-1:14];
         m_pos_ff     <= p_pos_ff;
         m_applied_ff <= p_applied_ff;
         m_zero_ff    <= p_zero_ff;
      end
   end

   // clipping and output register
   localparam logic [aapf_pkg::M_W-1:0] NEG_LIM = aapf_pkg::M_W'(64'h8000_0000);
   localparam logic [aapf_pkg::M_W-1:0] POS_LIM = aapf_pkg::M_W'(64'h7FFF_FFFF);

   logic [aapf_pkg::FORCE_W-1:0] f_in [3];
   logic [2:0]                   clip;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (m_pos_ff[c]) begin
            clip[c] = m_ff[c] > NEG_LIM;
            f_in[c] = clip[c] ? 32'h8000_0000 : 32'(-m_ff[c][aapf_pkg::FORCE_W-1:0]);
         end else begin
            clip[c] = m_ff[c] > POS_LIM;
            f_in[c] = clip[c] ? 32'h7FFF_FFFF : m_ff[c][aapf_pkg::FORCE_W-1:0];
         end
      end
   end

   logic rsp_valid_ff;
   logic [aapf_pkg::FORCE_W-1:0] fx_ff, fy_ff, fz_ff;
   logic applied_ff, sat_ff;
   logic live;
   assign live = m_applied_ff && !m_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= m_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fx_ff      <= live ? f_in[0] : '0;
         fy_ff      <= live ? f_in[1] : '0;
         fz_ff      <= live ? f_in[2] : '0;
         applied_ff <= m_applied_ff;
         sat_ff     <= live && (clip != 3'b000);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_force_x   = fx_ff;
   assign rsp_force_y   = fy_ff;
   assign rsp_force_z   = fz_ff;
   assign rsp_applied   = applied_ff;
   assign rsp_saturated = sat_ff;

endmodule
`default_nettype wire
